FILE: rtl/core/dht_pkg.sv
package dht_pkg;

  localparam int unsigned SLOTS_DEF      = 1021;
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam logic [63:0] HASH_SEED      = 64'd5381;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_UPDATED = 3'd1,
    ST_FOUND   = 3'd2,
    ST_MISSING = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_MOD_A,
    S_MOD_B,
    S_READ,
    S_WAIT,
    S_CHECK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  key_char;
    logic        key_last;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value_out;
    logic [9:0]  live_count;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } mod_ctl_t;

endpackage

FILE: rtl/core/double_hash_table.sv
// Channel | Ports                         | Beat
// input   | in_item, start, busy          | one key byte; start && !busy
// result  | out_item, out_valid           | one cycle strobe, no stall
// A byte without key_last only updates the hash. On the last byte two remainder units,
// each a shared multiplier run, give the start index and stride; probing goes through
// read, registered data and compare for each slot, up to SLOTS slots.
// For the undefined op or a full table the strobe follows without remainders or probing;
// busy stays high through the strobe cycle.
// After reset a clearing pass over every slot holds busy high. The receiver cannot stall.
module double_hash_table #(
  parameter int unsigned SLOTS      = dht_pkg::SLOTS_DEF,
  parameter int unsigned VALUE_BITS = dht_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dht_pkg::in_item_t   in_item,
  output logic                out_valid,
  output dht_pkg::out_item_t  out_item
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned EW = 66;
  localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);

  dht_pkg::state_t state_r, state_nxt;

  logic [63:0]           hash_r;
  logic [63:0]           key_r;
  logic [1:0]            op_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [AW-1:0]         idx_r;
  logic [AW-1:0]         stride_r;
  logic [AW:0]           probes_r;
  logic [CW-1:0]         count_r;
  logic [2:0]            status_r;
  logic [31:0]           vout_r;
  logic                  ov_r;

  logic                  mod_go;
  logic [AW-1:0]         rem_a, rem_b;
  dht_pkg::mod_ctl_t     ctl_a, ctl_b;

  logic                  e_we, v_we;
  logic [AW-1:0]         e_waddr;
  logic [EW-1:0]         e_wdata, e_rdata;
  logic [VALUE_BITS-1:0] v_rdata;

  logic                  accept;
  logic [63:0]           hash_next;
  logic                  s_used, s_active, s_match;
  logic [AW:0]           idx_sum;
  logic [AW-1:0]         idx_step;

  dht_mod #(.DIVISOR(SLOTS), .OUT_W(AW)) u_mod_a (
    .clk, .rst_n, .start(mod_go), .dividend(key_r), .remainder(rem_a), .ctl(ctl_a)
  );
  dht_mod #(.DIVISOR(SLOTS - 2), .OUT_W(AW)) u_mod_b (
    .clk, .rst_n, .start(mod_go), .dividend(key_r), .remainder(rem_b), .ctl(ctl_b)
  );

  dht_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_entry_ram (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(idx_r), .rdata(e_rdata)
  );
  dht_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_value_ram (
    .clk, .we(v_we), .waddr(idx_r), .wdata(val_r), .raddr(idx_r), .rdata(v_rdata)
  );

  assign accept    = start && !busy;
  assign hash_next = (in_item.key_char != 8'd0)
                   ? ({hash_r[58:0], 5'd0} + hash_r) + {56'd0, in_item.key_char} : hash_r;
  assign s_used    = e_rdata[65];
  assign s_active  = e_rdata[64];
  assign s_match   = e_rdata[63:0] == key_r;
  assign idx_sum   = {1'b0, idx_r} + {1'b0, stride_r};
  assign idx_step  = (idx_sum >= (AW+1)'(SLOTS)) ? AW'(idx_sum - (AW+1)'(SLOTS))
                                                  : idx_sum[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dht_pkg::S_IDLE:  if (accept && in_item.key_last) state_nxt = dht_pkg::S_MOD_A;
      dht_pkg::S_CLEAR: if (idx_r == LAST_IDX) state_nxt = dht_pkg::S_IDLE;
      dht_pkg::S_MOD_A: begin
        if (op_r == dht_pkg::OP_NONE) begin
          state_nxt = dht_pkg::S_DONE;
        end else if (op_r == dht_pkg::OP_INSERT && count_r >= CW'(SLOTS)) begin
          state_nxt = dht_pkg::S_DONE;
        end else begin
          state_nxt = dht_pkg::S_MOD_B;
        end
      end
      dht_pkg::S_MOD_B: if (ctl_a.done && ctl_b.done) state_nxt = dht_pkg::S_READ;
      dht_pkg::S_READ:  state_nxt = dht_pkg::S_WAIT;
      dht_pkg::S_WAIT:  state_nxt = dht_pkg::S_CHECK;
      dht_pkg::S_CHECK: begin
        if (op_r == dht_pkg::OP_INSERT) begin
          if (!s_active || s_match || probes_r == (AW+1)'(SLOTS - 1)) begin
            state_nxt = dht_pkg::S_DONE;
          end else begin
            state_nxt = dht_pkg::S_READ;
          end
        end else if (!s_used || s_match || probes_r == (AW+1)'(SLOTS - 1)) begin
          state_nxt = dht_pkg::S_DONE;
        end else begin
          state_nxt = dht_pkg::S_READ;
        end
      end
      dht_pkg::S_DONE:  state_nxt = dht_pkg::S_IDLE;
      default:          state_nxt = dht_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mod_go  = 1'b0;
    e_we    = 1'b0;
    v_we    = 1'b0;
    e_waddr = idx_r;
    e_wdata = {2'b11, key_r};
    unique case (state_r)
      dht_pkg::S_CLEAR: begin
        e_we    = 1'b1;
        e_wdata = '0;
      end
      dht_pkg::S_MOD_A: mod_go = (state_nxt == dht_pkg::S_MOD_B);
      dht_pkg::S_CHECK: begin
        if (op_r == dht_pkg::OP_INSERT) begin
          if (!s_active) begin
            e_we = 1'b1;
            v_we = 1'b1;
          end else if (s_match) begin
            v_we = 1'b1;
          end
        end else if (op_r == dht_pkg::OP_REMOVE && s_used && s_match && s_active) begin
          e_we    = 1'b1;
          e_wdata = {2'b10, key_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= dht_pkg::S_CLEAR;
      idx_r    <= '0;
      hash_r   <= dht_pkg::HASH_SEED;
      count_r  <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= 1'b0;
      unique case (state_r)
        dht_pkg::S_IDLE: begin
          if (accept) begin
            if (in_item.key_last) begin
              key_r    <= hash_next;
              hash_r   <= dht_pkg::HASH_SEED;
              op_r     <= in_item.op;
              val_r    <= VALUE_BITS'(in_item.value);
              status_r <= (in_item.op == dht_pkg::OP_INSERT) ? dht_pkg::ST_FULL
                                                             : dht_pkg::ST_MISSING;
              vout_r   <= '0;
              probes_r <= '0;
            end else begin
              hash_r <= hash_next;
            end
          end
        end
        dht_pkg::S_CLEAR: idx_r <= idx_r + AW'(1);
        dht_pkg::S_MOD_B: begin
          if (ctl_a.done && ctl_b.done) begin
            idx_r    <= rem_a;
            stride_r <= rem_b + AW'(1);
          end
        end
        dht_pkg::S_CHECK: begin
          probes_r <= probes_r + (AW+1)'(1);
          idx_r    <= idx_step;
          if (op_r == dht_pkg::OP_INSERT) begin
            if (!s_active) begin
              status_r <= dht_pkg::ST_NEW;
              count_r  <= count_r + CW'(1);
            end else if (s_match) begin
              status_r <= dht_pkg::ST_UPDATED;
            end
          end else if (s_used && s_match && s_active) begin
            status_r <= dht_pkg::ST_FOUND;
            vout_r   <= 32'(v_rdata);
            if (op_r == dht_pkg::OP_REMOVE) count_r <= count_r - CW'(1);
          end
        end
        dht_pkg::S_DONE: ov_r <= 1'b1;
        default: ;
      endcase
    end
  end

  assign busy                = (state_r != dht_pkg::S_IDLE) || ov_r;
  assign out_valid           = ov_r;
  assign out_item.status     = status_r;
  assign out_item.value_out  = vout_r;
  assign out_item.live_count = 10'(count_r);

endmodule

FILE: rtl/core/dht_ram.sv
module dht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/dht_mod.sv
module dht_mod #(
  parameter int unsigned DIVISOR = 1021,
  parameter int unsigned OUT_W   = $clog2(DIVISOR)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [63:0]       dividend,
  output logic [OUT_W-1:0]  remainder,
  output dht_pkg::mod_ctl_t ctl
);

  localparam logic [31:0] DIV   = 32'(DIVISOR);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIVISOR);

  logic [63:0] shift_r;
  logic [31:0] x_r;
  logic [63:0] prod_r;
  logic [31:0] t_r;
  logic [15:0] rem_r;
  logic [2:0]  ph_r;
  logic [1:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  logic [31:0] x_cur;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [15:0] rem_fix;

  assign x_cur   = {rem_r, shift_r[63:48]};
  assign mul_a   = ph_r[0] ? x_cur : prod_r[63:32];
  assign mul_b   = ph_r[0] ? RECIP : DIV;
  assign mul_p   = 64'(mul_a) * 64'(mul_b);
  assign rem_fix = (t_r >= DIV) ? 16'(t_r - DIV) : t_r[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 3'b001;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        ph_r    <= 3'b001;
        cnt_r   <= '0;
        shift_r <= dividend;
        rem_r   <= '0;
      end else if (busy_r) begin
        ph_r <= {ph_r[1:0], ph_r[2]};
        if (ph_r[0]) begin
          x_r     <= x_cur;
          prod_r  <= mul_p;
          shift_r <= {shift_r[47:0], 16'd0};
        end
        if (ph_r[1]) begin
          t_r <= x_r - mul_p[31:0];
        end
        if (ph_r[2]) begin
          rem_r <= rem_fix;
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd3) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  assign remainder = rem_r[OUT_W-1:0];
  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;

endmodule

FILE: rtl/core/dht_checker.sv
module dht_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input dht_pkg::out_item_t out_item
);

  a_busy_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("strobe while not busy");
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held over two cycles");
  a_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.status <= dht_pkg::ST_FULL) else $error("bad status");
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != dht_pkg::ST_FOUND) |-> out_item.value_out == 32'd0)
    else $error("value on a miss");
  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid) else $error("strobe straight after a beat");

endmodule

bind double_hash_table dht_checker u_dht_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_item
);

FILE: verif/double_hash_table_checker.sv
`timescale 1ns / 100ps

module double_hash_table_checker #(
  parameter int unsigned SLOTS = dht_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  dht_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  dht_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending_ops,
  output int                 ops_seen
);

  logic [63:0]        key_hash;
  bit                 used_tbl [SLOTS];
  bit                 live_tbl [SLOTS];
  logic [63:0]        hash_tbl [SLOTS];
  logic [31:0]        val_tbl  [SLOTS];
  int unsigned        live_entries;
  dht_pkg::out_item_t expected_results[$];

  function automatic dht_pkg::out_item_t apply_op(dht_pkg::in_item_t it, logic [63:0] h);
    dht_pkg::out_item_t r;
    int unsigned        idx, stride, n;
    bit                 ended;
    r.status = dht_pkg::ST_MISSING;
    r.value_out = '0;
    ended = 0;
    idx = h % SLOTS;
    stride = h % (SLOTS - 2) + 1;
    if (it.op == dht_pkg::OP_INSERT) begin
      r.status = dht_pkg::ST_FULL;
      if (live_entries < SLOTS) begin
        for (n = 0; n < SLOTS && !ended; n++) begin
          if (live_tbl[idx]) begin
            if (hash_tbl[idx] == h) begin
              val_tbl[idx] = it.value;
              r.status = dht_pkg::ST_UPDATED;
              ended = 1;
            end
          end else begin
            live_tbl[idx] = 1;
            used_tbl[idx] = 1;
            hash_tbl[idx] = h;
            val_tbl[idx] = it.value;
            live_entries++;
            r.status = dht_pkg::ST_NEW;
            ended = 1;
          end
          if (!ended) idx = (idx + stride) % SLOTS;
        end
      end
    end else if (it.op == dht_pkg::OP_REMOVE || it.op == dht_pkg::OP_GET) begin
      for (n = 0; n < SLOTS && !ended; n++) begin
        if (!used_tbl[idx]) begin
          ended = 1;
        end else if (hash_tbl[idx] == h) begin
          ended = 1;
          if (live_tbl[idx]) begin
            r.status = dht_pkg::ST_FOUND;
            r.value_out = val_tbl[idx];
            if (it.op == dht_pkg::OP_REMOVE) begin
              live_tbl[idx] = 0;
              live_entries--;
            end
          end
        end
        if (!ended) idx = (idx + stride) % SLOTS;
      end
    end
    r.live_count = live_entries[9:0];
    return r;
  endfunction

  always @(posedge clk) begin
    dht_pkg::out_item_t exp_r;
    logic [63:0]        nh;
    if (!rst_n) begin
      key_hash <= dht_pkg::HASH_SEED;
      live_entries = 0;
      fail_count <= 0;
      ops_seen <= 0;
      pending_ops <= 0;
      for (int i = 0; i < SLOTS; i++) begin
        used_tbl[i] = 0;
        live_tbl[i] = 0;
        hash_tbl[i] = '0;
      end
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result beat %p", out_item);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_item.status !== exp_r.status || out_item.value_out !== exp_r.value_out ||
              out_item.live_count !== exp_r.live_count) begin
            if (fail_count < 10)
              $display("Mismatch: expected st=%0d val=%h cnt=%0d, got st=%0d val=%h cnt=%0d",
                       exp_r.status, exp_r.value_out, exp_r.live_count,
                       out_item.status, out_item.value_out, out_item.live_count);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        nh = key_hash;
        if (in_item.key_char != 8'd0) nh = nh * 33 + in_item.key_char;
        if (in_item.key_last) begin
          expected_results.push_back(apply_op(in_item, nh));
          key_hash <= dht_pkg::HASH_SEED;
          ops_seen <= ops_seen + 1;
        end else begin
          key_hash <= nh;
        end
      end
      pending_ops <= expected_results.size();
    end
  end

endmodule

FILE: verif/double_hash_table_tb.sv
`timescale 1ns / 100ps

module double_hash_table_tb;

  localparam int WATCHDOG = 20000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  dht_pkg::in_item_t  in_item;
  logic               out_valid;
  dht_pkg::out_item_t out_item;
  int                 fail_count, pending_ops, ops_seen;
  int                 quiet_cycles;
  int                 sent;
  logic [7:0]         keyset [16][4];
  int                 keylen [16];

  double_hash_table dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  double_hash_table_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .fail_count(fail_count),
    .pending_ops(pending_ops), .ops_seen(ops_seen)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_beat(dht_pkg::op_t op, logic [7:0] ch, logic lst, logic [31:0] v);
    start <= 1'b1;
    in_item <= '{op: op, key_char: ch, key_last: lst, value: v};
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_key(int k, dht_pkg::op_t op, logic [31:0] v);
    for (int i = 0; i < keylen[k]; i++) begin
      send_beat(op, keyset[k][i], i == keylen[k] - 1, v);
      if (i != keylen[k] - 1) idle_gap();
    end
  endtask

  initial begin
    dht_pkg::op_t op;
    int           k;
    start = 1'b0;
    in_item = '0;
    rst_n = 1'b0;
    sent = 0;
    for (int i = 0; i < 16; i++) begin
      keylen[i] = $urandom_range(1, 4);
      for (int j = 0; j < 4; j++) keyset[i][j] = 8'($urandom_range(0, 255));
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(dht_pkg::OP_GET, 8'h00, 1'b1, '0);
    send_beat(dht_pkg::OP_INSERT, 8'h00, 1'b1, 32'hFFFF_FFFF);
    send_beat(dht_pkg::OP_INSERT, 8'h00, 1'b1, 32'h0000_0001);
    send_beat(dht_pkg::OP_GET, 8'h00, 1'b1, '0);
    send_beat(dht_pkg::OP_INSERT, 8'hFF, 1'b0, '0);
    send_beat(dht_pkg::OP_INSERT, 8'h00, 1'b0, '0);
    send_beat(dht_pkg::OP_INSERT, 8'h01, 1'b1, 32'h0);
    send_beat(dht_pkg::OP_REMOVE, 8'hFF, 1'b0, '0);
    send_beat(dht_pkg::OP_REMOVE, 8'h01, 1'b1, '0);
    send_beat(dht_pkg::OP_REMOVE, 8'hFF, 1'b0, '0);
    send_beat(dht_pkg::OP_REMOVE, 8'h01, 1'b1, '0);
    send_beat(dht_pkg::OP_GET, 8'hFF, 1'b0, '0);
    send_beat(dht_pkg::OP_GET, 8'h01, 1'b1, '0);
    send_beat(dht_pkg::OP_INSERT, 8'hFF, 1'b0, '0);
    send_beat(dht_pkg::OP_INSERT, 8'h01, 1'b1, 32'hA5A5_5A5A);
    send_beat(dht_pkg::OP_NONE, 8'h80, 1'b1, 32'hFFFF_FFFF);
    send_beat(dht_pkg::OP_REMOVE, 8'h00, 1'b1, '0);
    send_beat(dht_pkg::OP_REMOVE, 8'h00, 1'b1, '0);
    send_beat(dht_pkg::OP_GET, 8'h00, 1'b1, '0);

    while (sent < 1800) begin
      if (sent > 900 && sent < 1000) begin
        start <= 1'b0;
        @(posedge clk);
        wait (pending_ops == 0);
        @(posedge clk);
      end
      k = $urandom_range(0, 15);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: op = dht_pkg::OP_INSERT;
        4, 5:       op = dht_pkg::OP_REMOVE;
        6, 7, 8:    op = dht_pkg::OP_GET;
        default:    op = dht_pkg::op_t'($urandom_range(0, 3));
      endcase
      if ($urandom_range(0, 4) == 0) begin
        for (int i = 0; i < 3; i++) begin
          send_beat(op, 8'($urandom_range(0, 255)), i == 2, $urandom());
          if (i != 2) idle_gap();
        end
      end else begin
        send_key(k, op, $urandom());
      end
      idle_gap();
    end
    start <= 1'b0;

    @(posedge clk);
    wait (pending_ops == 0);
    repeat (20) @(posedge clk);
    $display("Ran %0d key beats, %0d table operations over a small key set", sent, ops_seen);
    $display("with inserts, updates, removes, tombstones, gets and the undefined op.");
    if (fail_count == 0 && pending_ops == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
